/* hw/rtl/ihexp_pkg.sv */
// Shared types, result codes and decode helpers for the hex record parser.
// No dependencies; used by the top, ihexp_core and ihexp_out_reg under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package ihexp_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam int unsigned UNIT_W = 3;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 3'd1;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_START = 2'd1;
    localparam logic [1:0] ERR_TYPE  = 2'd2;
    localparam logic [1:0] ERR_SUM   = 2'd3;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    // Reciprocal scale for the unit divide
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic        new_segment;
        logic [1:0]  error_code;
    } t_result;

    // ASCII hex digit to nibble; anything else reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            case (c) inside
                [8'h30:8'h39]: d = c - 8'h30;
                [8'h61:8'h66]: d = c - 8'h61 + 8'd10;
                [8'h41:8'h46]: d = c - 8'h41 + 8'd10;
                default:       d = 8'h00;
            endcase
            return d[3:0];
        end
    endfunction

    // ceil(2^16 / unit); unit zero behaves as one. Exact for 8-bit dividends.
    function automatic logic [RECIP_W-1:0] unit_recip(input logic [UNIT_W-1:0] u);
        logic [RECIP_W-1:0] r;
        begin
            case (u)
                3'd2:    r = 17'd32768;
                3'd3:    r = 17'd21846;
                3'd4:    r = 17'd16384;
                3'd5:    r = 17'd13108;
                3'd6:    r = 17'd10923;
                3'd7:    r = 17'd9363;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/intel_hex_record_parser_unit.sv */
// Intel HEX record parser: one ASCII character per transfer in, data bytes and
// record status out. An accepted character is held in the input register, and
// its result is then loaded into the result register, where it is offered.
// Throughput: one character per cycle; the input stalls only while the result
// register is full and stalled.
// Synchronous active-low reset returns the parser to waiting for a colon,
// clears both stages and sets unit_bytes to 1.
// Depends on ihexp_pkg, ihexp_in_reg, ihexp_core, ihexp_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character input
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_in,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_address,
    output logic [7:0]       o_data_byte,
    output logic             o_new_segment,
    output logic [1:0]       o_error_code,
    // configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [ihexp_pkg::UNIT_W-1:0] i_cfg_data
);

    // unit_bytes register; always ready, written on any cfg transfer
    logic [ihexp_pkg::UNIT_W-1:0] r_unit_bytes;

    logic               in_valid;
    logic [7:0]         in_char;
    logic               out_free;
    logic               advance;
    ihexp_pkg::t_result core_res;
    ihexp_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_bytes <= ihexp_pkg::UNIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_unit_bytes <= i_cfg_data;
        end
    end

    // The held character is parsed once the result register can take
    // whatever it produces (it may produce nothing).
    assign advance = in_valid && out_free;

    ihexp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_char    (i_char_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_char    (in_char)
    );

    // All per-character work sits between the two registers.
    ihexp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_char       (in_char),
        .i_unit_bytes (r_unit_bytes),
        .o_result     (core_res)
    );

    ihexp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_res),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign o_out_valid   = out_res.valid;
    assign o_kind        = out_res.kind;
    assign o_address     = out_res.address;
    assign o_data_byte   = out_res.data_byte;
    assign o_new_segment = out_res.new_segment;
    assign o_error_code  = out_res.error_code;

endmodule

`default_nettype wire

/* hw/rtl/ihexp_in_reg.sv */
// Input register stage: holds one character until the parser takes it.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps
`default_nettype none

module ihexp_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_char
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       take;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_char  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= i_char;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ihexp_core.sv */
// Record parser state and per-character decode; result is combinational.
// Depends on ihexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihexp_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire logic [7:0]                   i_char,
    input  wire logic [ihexp_pkg::UNIT_W-1:0] i_unit_bytes,
    output ihexp_pkg::t_result                o_result
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_OFFSET,
        PH_TYPE,
        PH_DATA,
        PH_EXTRA,
        PH_CHECK
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic        r_half,    n_half;
    logic [3:0]  r_nyb,     n_nyb;
    logic [7:0]  r_idx,     n_idx;
    logic [7:0]  r_count,   n_count;
    logic [15:0] r_offset,  n_offset;
    logic [7:0]  r_type,    n_type;
    logic [7:0]  r_sum,     n_sum;
    logic [15:0] r_upper,   n_upper;
    logic [15:0] r_fbuf,    n_fbuf;
    logic [16:0] r_expect,  n_expect;
    logic        r_pend,    n_pend;
    logic        r_halted,  n_halted;

    logic [7:0]  b;
    logic [7:0]  sum_b;
    logic [7:0]  idx_inc;
    logic [15:0] fbuf_sh;
    logic [24:0] quot_prod;
    logic [7:0]  quot;
    ihexp_pkg::t_result res;

    assign b       = {r_nyb, ihexp_pkg::hex_value(i_char)};
    assign sum_b   = r_sum + b;
    assign idx_inc = r_idx + 8'd1;
    assign fbuf_sh = {r_fbuf[7:0], b};

    // count / unit by reciprocal multiply
    assign quot_prod = 25'(r_count) * 25'(ihexp_pkg::unit_recip(i_unit_bytes));
    assign quot      = quot_prod[ihexp_pkg::RECIP_SHIFT +: 8];

    always_comb begin
        n_phase  = r_phase;
        n_half   = r_half;
        n_nyb    = r_nyb;
        n_idx    = r_idx;
        n_count  = r_count;
        n_offset = r_offset;
        n_type   = r_type;
        n_sum    = r_sum;
        n_upper  = r_upper;
        n_fbuf   = r_fbuf;
        n_expect = r_expect;
        n_pend   = r_pend;
        n_halted = r_halted;
        res      = '0;

        if (i_fire && !r_halted) begin
            if (r_phase == PH_WAIT) begin
                if (i_char == ihexp_pkg::CHAR_COLON) begin
                    n_phase = PH_COUNT;
                    n_half  = 1'b0;
                    n_nyb   = 4'h0;
                end else if (i_char != ihexp_pkg::CHAR_CR &&
                             i_char != ihexp_pkg::CHAR_LF) begin
                    n_halted       = 1'b1;
                    res.valid      = 1'b1;
                    res.kind       = ihexp_pkg::KIND_ERROR;
                    res.error_code = ihexp_pkg::ERR_START;
                end
            end else if (!r_half) begin
                n_nyb  = ihexp_pkg::hex_value(i_char);
                n_half = 1'b1;
            end else begin
                n_half = 1'b0;
                case (r_phase)
                    PH_COUNT: begin
                        n_count = b;
                        if (b == 8'h00) begin
                            n_halted  = 1'b1;
                            res.valid = 1'b1;
                            res.kind  = ihexp_pkg::KIND_END;
                        end else begin
                            n_sum   = b;
                            n_idx   = 8'd0;
                            n_fbuf  = 16'h0000;
                            n_phase = PH_OFFSET;
                        end
                    end
                    PH_OFFSET: begin
                        n_sum  = sum_b;
                        n_fbuf = fbuf_sh;
                        n_idx  = idx_inc;
                        if (idx_inc >= 8'd2) begin
                            n_offset = fbuf_sh;
                            n_phase  = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type = b;
                        n_idx  = 8'd0;
                        n_fbuf = 16'h0000;
                        if (b == ihexp_pkg::REC_DATA) begin
                            if ({1'b0, r_offset} != r_expect) begin
                                n_pend = 1'b1;
                            end
                            n_expect = {1'b0, r_offset} + {9'd0, quot};
                            n_phase  = PH_DATA;
                        end else if (b == ihexp_pkg::REC_ELA ||
                                     b == ihexp_pkg::REC_SLA) begin
                            n_sum   = sum_b;
                            n_pend  = 1'b1;
                            n_phase = PH_EXTRA;
                        end else begin
                            n_halted       = 1'b1;
                            res.valid      = 1'b1;
                            res.kind       = ihexp_pkg::KIND_ERROR;
                            res.error_code = ihexp_pkg::ERR_TYPE;
                        end
                    end
                    PH_DATA: begin
                        n_sum = sum_b;
                        if (r_idx == 8'd0) begin
                            res.new_segment = r_pend;
                            n_pend          = 1'b0;
                        end
                        res.valid     = 1'b1;
                        res.kind      = ihexp_pkg::KIND_DATA;
                        res.data_byte = b;
                        res.address   = {r_upper, 16'h0000} + {16'h0000, r_offset}
                                        + {24'h000000, r_idx};
                        n_idx = idx_inc;
                        if (idx_inc >= r_count) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_EXTRA: begin
                        n_sum  = sum_b;
                        n_fbuf = fbuf_sh;
                        n_idx  = idx_inc;
                        if (r_type == ihexp_pkg::REC_ELA && idx_inc >= 8'd2) begin
                            n_upper = fbuf_sh;
                            n_phase = PH_CHECK;
                        end else if (r_type != ihexp_pkg::REC_ELA && idx_inc >= 8'd4) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        res.valid = 1'b1;
                        if (b == 8'(-r_sum)) begin
                            n_phase  = PH_WAIT;
                            res.kind = ihexp_pkg::KIND_ACCEPT;
                        end else begin
                            n_halted       = 1'b1;
                            res.kind       = ihexp_pkg::KIND_ERROR;
                            res.error_code = ihexp_pkg::ERR_SUM;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_half   <= 1'b0;
            r_nyb    <= 4'h0;
            r_idx    <= 8'd0;
            r_count  <= 8'd0;
            r_offset <= 16'h0000;
            r_type   <= 8'd0;
            r_sum    <= 8'd0;
            r_upper  <= 16'h0000;
            r_fbuf   <= 16'h0000;
            r_expect <= 17'd0;
            r_pend   <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_half   <= n_half;
            r_nyb    <= n_nyb;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_type   <= n_type;
            r_sum    <= n_sum;
            r_upper  <= n_upper;
            r_fbuf   <= n_fbuf;
            r_expect <= n_expect;
            r_pend   <= n_pend;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ihexp_out_reg.sv */
// Result register: holds one result until the consumer takes it.
// Depends on ihexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihexp_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  ihexp_pkg::t_result      i_result,
    input  wire logic               i_stall,
    output logic                    o_free,
    output ihexp_pkg::t_result      o_result
);

    logic               r_valid;
    ihexp_pkg::t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    always_comb begin
        o_result       = r_res;
        o_result.valid = r_valid;
    end

endmodule

`default_nettype wire

/* tb/hex_stream_checker.sv */
// Checker for the hex record parser: watches the character, result and
// configuration transfers, predicts each result and compares it field by field.
// Depends on ihexp_pkg for result kinds, error codes and record types.
`timescale 1ns / 1ps

module hex_stream_checker
    import ihexp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [7:0]        i_char_in,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [1:0]        i_kind,
    input  wire logic [31:0]       i_address,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_new_segment,
    input  wire logic [1:0]        i_error_code,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [UNIT_W-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic        new_segment;
        logic [1:0]  error_code;
    } parse_result_t;

    typedef enum logic [2:0] {
        P_WAIT, P_COUNT, P_OFFSET, P_TYPE, P_DATA, P_EXTRA, P_CHECK
    } parse_stage_t;

    parse_result_t due_results[$];
    int            fails = 0;

    // parser state as seen from outside
    logic [UNIT_W-1:0] unit_sel;
    parse_stage_t      stage;
    logic              digit_hi;
    logic [3:0]        hi_nib;
    logic [7:0]        idx, cnt, rec_type, csum;
    logic [15:0]       rec_off, upper, shift_buf;
    logic [31:0]       next_off;
    logic              seg_flag, stopped;

    task automatic reset_model();
        unit_sel  = UNIT_RESET;
        stage     = P_WAIT;
        digit_hi  = 1'b0;
        hi_nib    = '0;
        idx       = '0;
        cnt       = '0;
        rec_type  = '0;
        csum      = '0;
        rec_off   = '0;
        upper     = '0;
        shift_buf = '0;
        next_off  = '0;
        seg_flag  = 1'b0;
        stopped   = 1'b0;
    endtask

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c[3:0];
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return 4'(c[3:0] + 4'd9);
        return 4'd0;
    endfunction

    // one assembled byte moves the record along
    task automatic take_byte(input logic [7:0] b, output logic got,
                             output parse_result_t r);
        logic [2:0] unit_div;
        got = 1'b0;
        r   = '0;
        case (stage)
            P_COUNT: begin
                cnt = b;
                if (b == 8'd0) begin
                    stopped = 1'b1;
                    got     = 1'b1;
                    r.kind  = KIND_END;
                end else begin
                    csum      = b;
                    idx       = '0;
                    shift_buf = '0;
                    stage     = P_OFFSET;
                end
            end
            P_OFFSET: begin
                csum      = csum + b;
                shift_buf = {shift_buf[7:0], b};
                idx       = idx + 8'd1;
                if (idx >= 8'd2) begin
                    rec_off = shift_buf;
                    stage   = P_TYPE;
                end
            end
            P_TYPE: begin
                rec_type  = b;
                idx       = '0;
                shift_buf = '0;
                if (b == REC_DATA) begin
                    unit_div = (unit_sel == 3'd0) ? 3'd1 : unit_sel;
                    if (32'(rec_off) != next_off) seg_flag = 1'b1;
                    next_off = 32'(rec_off) + 32'(cnt) / 32'(unit_div);
                    stage    = P_DATA;
                end else if (b == REC_ELA || b == REC_SLA) begin
                    csum     = csum + b;
                    seg_flag = 1'b1;
                    stage    = P_EXTRA;
                end else begin
                    stopped      = 1'b1;
                    got          = 1'b1;
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_TYPE;
                end
            end
            P_DATA: begin
                csum = csum + b;
                if (idx == 8'd0) begin
                    r.new_segment = seg_flag;
                    seg_flag      = 1'b0;
                end
                r.address   = {upper, 16'h0000} + 32'(rec_off) + 32'(idx);
                r.data_byte = b;
                r.kind      = KIND_DATA;
                got         = 1'b1;
                idx         = idx + 8'd1;
                if (idx >= cnt) stage = P_CHECK;
            end
            P_EXTRA: begin
                csum      = csum + b;
                shift_buf = {shift_buf[7:0], b};
                idx       = idx + 8'd1;
                if (rec_type == REC_ELA && idx >= 8'd2) begin
                    upper = shift_buf;
                    stage = P_CHECK;
                end else if (rec_type != REC_ELA && idx >= 8'd4) begin
                    stage = P_CHECK;
                end
            end
            P_CHECK: begin
                got = 1'b1;
                if (b == 8'(8'd0 - csum)) begin
                    stage  = P_WAIT;
                    r.kind = KIND_ACCEPT;
                end else begin
                    stopped      = 1'b1;
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_SUM;
                end
            end
            default: stage = P_WAIT;
        endcase
    endtask

    task automatic parse_char(input logic [7:0] c, output logic got,
                              output parse_result_t r);
        got = 1'b0;
        r   = '0;
        if (stopped) return;
        if (stage == P_WAIT) begin
            if (c == CHAR_CR || c == CHAR_LF) return;
            if (c != CHAR_COLON) begin
                stopped      = 1'b1;
                got          = 1'b1;
                r.kind       = KIND_ERROR;
                r.error_code = ERR_START;
                return;
            end
            stage    = P_COUNT;
            digit_hi = 1'b0;
            hi_nib   = '0;
            return;
        end
        if (!digit_hi) begin
            hi_nib   = nibble_of(c);
            digit_hi = 1'b1;
            return;
        end
        digit_hi = 1'b0;
        take_byte({hi_nib, nibble_of(c)}, got, r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        parse_result_t want, seen;
        logic          got;
        if (!i_rst_n) begin
            reset_model();
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) unit_sel = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_char_in, got, want);
                if (got) due_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_kind, i_address, i_data_byte, i_new_segment, i_error_code};
                if (due_results.size() == 0) begin
                    $display("%0t: result expected none, got kind %0d addr %0h data %0h",
                             $time, seen.kind, seen.address, seen.data_byte);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(seen.kind));
                    check_field("address", want.address, seen.address);
                    check_field("data_byte", 32'(want.data_byte), 32'(seen.data_byte));
                    check_field("new_segment", 32'(want.new_segment),
                                32'(seen.new_segment));
                    check_field("error_code", 32'(want.error_code),
                                32'(seen.error_code));
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/testbench.sv */
// Top of the hex record parser bench: clock, reset, character stimulus,
// configuration writes, receiver stalls, watchdog and verdict.
// Depends on ihexp_pkg, intel_hex_record_parser_unit and hex_stream_checker.
`timescale 1ns / 1ps

module testbench;
    import ihexp_pkg::*;

    // Quiet cycles allowed before the run is declared hung. The worst honest
    // quiet stretch is a solid receiver stall or a sender gap or a settle
    // before a register write, so this is very generous.
    localparam int unsigned IDLE_LIMIT   = 4000;
    // Result lands after its character passes both registers; settle a little longer.
    localparam int unsigned SETTLE_TICKS = 8;
    // Characters per register setting in the random part; each stretch
    // overruns by part of a record.
    localparam int unsigned PHASE_CHARS  = 120;

    localparam logic [1:0] FILL_RANDOM = 2'd0;
    localparam logic [1:0] FILL_EDGE   = 2'd1;   // alternating 00 / FF

    localparam logic [7:0] REC_EOF = 8'h01;

    // how the file is brought to its halt
    localparam int END_OF_FILE   = 0;
    localparam int END_BAD_START = 1;
    localparam int END_BAD_TYPE  = 2;
    localparam int END_BAD_SUM   = 3;

    // receiver behaviour
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_SOLID  = 2;

    // unit sizes visited in turn; every 3-bit value, zero included
    localparam logic [UNIT_W-1:0] UNIT_PLAN [8] = '{
        3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [7:0]        char_in   = 8'h00;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [UNIT_W-1:0] cfg_data  = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_kind;
    logic [31:0]       o_address;
    logic [7:0]        o_data_byte;
    logic              o_new_segment;
    logic [1:0]        o_error_code;
    logic              o_cfg_ready;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    int                burst_left  = 0;
    int                chars_sent  = 0;
    logic [UNIT_W-1:0] unit_now    = UNIT_RESET;
    logic [31:0]       planned_off = '0;

    always #1 clk = ~clk;

    intel_hex_record_parser_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_in     (char_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (o_kind),
        .o_address     (o_address),
        .o_data_byte   (o_data_byte),
        .o_new_segment (o_new_segment),
        .o_error_code  (o_error_code),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    hex_stream_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (o_in_stall),
        .i_char_in     (char_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .i_kind        (o_kind),
        .i_address     (o_address),
        .i_data_byte   (o_data_byte),
        .i_new_segment (o_new_segment),
        .i_error_code  (o_error_code),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Receiver: stretches of free flow, of coin-toss stalls and of solid
    // stalls, each of random length, independent of the sender.
    int stall_left = 0;
    int stall_mode = STALL_NONE;

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_SOLID);
            stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 25)
                                                      : $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
            default:      out_stall <= 1'b1;
        endcase
    end

    // Watchdog: any transfer on any channel counts as progress.
    int unsigned quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One character transfer. The sender runs in bursts; when a burst is
    // spent valid drops for a random gap before the next one starts. Valid
    // stays high across back-to-back transfers, so it is never dropped and
    // raised in the same step.
    task automatic send_char(input logic [7:0] c);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        burst_left--;
        chars_sent++;
    endtask

    // Hex digit in random case. A zero digit may instead be any non-hex
    // character, which the parser reads as zero - checksum still holds.
    function automatic logic [7:0] digit_char(input logic [3:0] n,
                                              input logic noisy);
        logic [7:0] c;
        if (noisy && n == 4'd0 && $urandom_range(0, 2) == 0) begin
            c = 8'($urandom_range(0, 255));
            if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
                    || (c >= 8'h61 && c <= 8'h66))
                c = c | 8'h80;
            return c;
        end
        if (n < 4'd10) return 8'(8'h30 + n);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10);
    endfunction

    task automatic send_hex(input logic [7:0] b, input logic noisy);
        send_char(digit_char(b[7:4], noisy));
        send_char(digit_char(b[3:0], noisy));
    endtask

    // Whole record, optionally preceded by line ends. The payload length
    // follows the type, not the count, as the parser does for 04 and 05.
    task automatic send_record(input logic [7:0] rtype, input logic [7:0] count,
                               input logic [15:0] offset, input logic [31:0] xtra,
                               input logic [1:0] fill, input logic noisy,
                               input logic sum_bad);
        int         n;
        logic [7:0] sum, b;
        repeat ($urandom_range(0, 2)) send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        send_char(CHAR_COLON);
        send_hex(count, noisy);
        send_hex(offset[15:8], noisy);
        send_hex(offset[7:0], noisy);
        send_hex(rtype, noisy);
        sum = count + offset[15:8] + offset[7:0] + rtype;
        n = (rtype == REC_DATA) ? int'(count) :
            (rtype == REC_ELA)  ? 2 :
            (rtype == REC_SLA)  ? 4 : 0;
        for (int i = 0; i < n; i++) begin
            if (rtype == REC_DATA)
                b = (fill == FILL_EDGE) ? {8{i[0]}} : 8'($urandom_range(0, 255));
            else
                b = 8'(xtra >> (8 * (n - 1 - i)));
            send_hex(b, noisy);
            sum = sum + b;
        end
        b = 8'(8'd0 - sum);
        if (sum_bad) b = b ^ 8'(8'h01 << $urandom_range(0, 7));
        send_hex(b, noisy);
    endtask

    task automatic send_random_record();
        int          pick;
        logic [7:0]  count;
        logic [15:0] off;
        logic [31:0] xtra;
        logic [2:0]  unit_div;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            // mostly short records, the odd long one
            count = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(200, 255))
                                                 : 8'($urandom_range(1, 16));
            case ($urandom_range(0, 3))
                0, 1:    off = planned_off[15:0];     // carry on the segment
                2:       off = 16'($urandom_range(0, 65535));
                default: off = 16'hFFFF - 16'($urandom_range(0, 20));
            endcase
            send_record(REC_DATA, count, off, '0, FILL_RANDOM,
                        $urandom_range(0, 2) == 0, 1'b0);
            unit_div    = (unit_now == 3'd0) ? 3'd1 : unit_now;
            planned_off = 32'(off) + 32'(count) / 32'(unit_div);
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0:       xtra = 32'h0000_0000;
                1:       xtra = 32'h0000_FFFF;
                default: xtra = 32'($urandom_range(0, 65535));
            endcase
            send_record(REC_ELA, 8'($urandom_range(1, 255)),
                        16'($urandom_range(0, 65535)), xtra, FILL_RANDOM,
                        $urandom_range(0, 2) == 0, 1'b0);
        end else begin
            send_record(REC_SLA, 8'($urandom_range(1, 255)),
                        16'($urandom_range(0, 65535)), $urandom, FILL_RANDOM,
                        $urandom_range(0, 2) == 0, 1'b0);
        end
    endtask

    // Register writes only with the parser idle: hold the sender off until
    // every predicted result has come back, then let the pipe settle.
    task automatic set_unit(input logic [UNIT_W-1:0] v);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        unit_now = v;
    endtask

    // The parser halts for good on an end or an error and reset comes only
    // once, so each run closes the file one way, picked at random.
    task automatic send_closing();
        logic [7:0] c;
        logic [7:0] rtype;
        case ($urandom_range(END_OF_FILE, END_BAD_SUM))
            END_OF_FILE: begin
                send_record(REC_EOF, 8'h00, 16'h0000, '0, FILL_RANDOM, 1'b0, 1'b0);
            end
            END_BAD_START: begin
                c = 8'($urandom_range(0, 255));
                if (c == CHAR_COLON || c == CHAR_CR || c == CHAR_LF) c = 8'h58;
                send_char(c);
            end
            END_BAD_TYPE: begin
                case ($urandom_range(0, 2))
                    0:       rtype = REC_EOF;     // end record with a payload
                    1:       rtype = 8'($urandom_range(1, 3));
                    default: rtype = 8'($urandom_range(6, 255));
                endcase
                send_record(rtype, 8'($urandom_range(1, 16)), planned_off[15:0],
                            '0, FILL_RANDOM, 1'b0, 1'b0);
            end
            default: begin
                send_record(REC_DATA, 8'($urandom_range(1, 16)), planned_off[15:0],
                            '0, FILL_RANDOM, 1'b0, 1'b1);
            end
        endcase
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first record at offset zero is not a new segment; then
        // the top upper address, and a record whose offset runs past 16 bits
        // so the 32-bit address wraps. Data bytes are 00 and FF.
        send_record(REC_DATA, 8'h02, 16'h0000, '0, FILL_EDGE, 1'b0, 1'b0);
        send_record(REC_ELA, 8'h02, 16'h0000, 32'h0000_FFFF, FILL_RANDOM, 1'b0, 1'b0);
        send_record(REC_DATA, 8'h02, 16'hFFFF, '0, FILL_EDGE, 1'b0, 1'b0);
        planned_off = 32'h0001_0001;

        // Random records, one stretch per unit size.
        foreach (UNIT_PLAN[p]) begin
            set_unit(UNIT_PLAN[p]);
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) send_random_record();
        end

        send_closing();
        // the parser is halted now; these must produce nothing
        repeat (12) send_char(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
